@@ design/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising edge, skipped while reset is held.
`define LLQM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("llqm assertion failed");

// Check a property at each rising edge, reset included.
`define LLQM_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("llqm assertion failed");

`endif

@@ design/llqm_pkg.sv @@
`default_nettype none

package llqm_pkg;

    localparam int IN_W  = 8;
    localparam int OUT_W = 16;

    localparam logic [1:0] FN_PUSH   = 2'd0;
    localparam logic [1:0] FN_POP    = 2'd1;
    localparam logic [1:0] FN_REMOVE = 2'd2;
    localparam logic [1:0] FN_QUERY  = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_PUSH_DUP = 2'd1;
    localparam logic [1:0] STAT_REM_MISS = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_UNLINK,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

@@ design/linked_list_queue_manager.sv @@
`default_nettype none
// Channel   Dir  tdata fields (low bit first)
// s_axis    in   func[1:0], item_slot[7:2]
// m_axis    out  out_slot[5:0], got_item[6], in_queue[7], queue_empty[8], status[10:9]
//
// Push, pop and query go from accept to result through the registered membership and
// link reads, the update in ST_EXEC and the load of the output register in ST_FIN.
// Removing a slot other than the head walks the links from the head in ST_WALK and,
// unless it is the tail, relinks in ST_UNLINK; all use the single link table read port.
// After reset ST_CLEAR clears each membership table entry in turn; no word is taken.
// A finished result waits in the sequencer while the output register is stalled.

module linked_list_queue_manager #(
    parameter int QUEUE_SLOTS = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  wire logic [llqm_pkg::IN_W-1:0]    i_s_axis_tdata,   // func, item_slot
    output logic                              o_m_axis_tvalid,
    input  wire logic                         i_m_axis_tready,
    output logic      [llqm_pkg::OUT_W-1:0]   o_m_axis_tdata    // out_slot, got_item,
                                                               // in_queue, queue_empty, status
);
    import llqm_pkg::*;

    localparam int SW = (QUEUE_SLOTS > 2) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int CW = ((SW > 6) ? SW : 6) + 1;

    logic [SW-1:0] r_link_mem [QUEUE_SLOTS];
    logic          r_mark_mem [QUEUE_SLOTS];
    logic [SW-1:0] r_link_rd;
    logic          r_mark_rd;

    t_state        r_state, n_state;
    logic [SW-1:0] r_clr, n_clr;
    logic [SW-1:0] r_head, n_head;
    logic [SW-1:0] r_tail, n_tail;
    logic          r_nonempty, n_nonempty;
    logic [1:0]    r_func, n_func;
    logic [SW-1:0] r_slot, n_slot;
    logic          r_inr, n_inr;
    logic [SW-1:0] r_cur, n_cur;
    logic          r_got, n_got;
    logic [5:0]    r_oslot, n_oslot;
    logic          r_inq, n_inq;
    logic [1:0]    r_status, n_status;
    logic          r_out_valid, n_out_valid;
    logic [OUT_W-1:0] r_out_data, n_out_data;

    logic          mk_we, mk_wd;
    logic [SW-1:0] mk_wa, mk_ra;
    logic          lk_we;
    logic [SW-1:0] lk_wa, lk_wd, lk_ra;

    logic [CW-1:0] in_slot_ext;
    logic          accept;
    logic          member;

    assign in_slot_ext     = CW'(i_s_axis_tdata[7:2]);
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign member          = r_inr && r_mark_rd;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_head      = r_head;
        n_tail      = r_tail;
        n_nonempty  = r_nonempty;
        n_func      = r_func;
        n_slot      = r_slot;
        n_inr       = r_inr;
        n_cur       = r_cur;
        n_got       = r_got;
        n_oslot     = r_oslot;
        n_inq       = r_inq;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        mk_we       = 1'b0;
        mk_wa       = r_slot;
        mk_wd       = 1'b0;
        mk_ra       = SW'(in_slot_ext);
        lk_we       = 1'b0;
        lk_wa       = r_cur;
        lk_wd       = r_link_rd;
        lk_ra       = r_head;

        case (r_state)
            ST_CLEAR: begin
                mk_we = 1'b1;
                mk_wa = r_clr;
                n_clr = r_clr + 1'b1;
                if (r_clr == SW'(QUEUE_SLOTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_func   = i_s_axis_tdata[1:0];
                    n_slot   = SW'(in_slot_ext);
                    n_inr    = (in_slot_ext < CW'(QUEUE_SLOTS));
                    n_got    = 1'b0;
                    n_oslot  = '0;
                    n_inq    = 1'b0;
                    n_status = STAT_OK;
                    n_state  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_FIN;
                case (r_func)
                    FN_PUSH: begin
                        if (member || !r_inr) begin
                            n_status = STAT_PUSH_DUP;
                            n_inq    = member;
                        end else begin
                            mk_we = 1'b1;
                            mk_wd = 1'b1;
                            if (r_nonempty) begin
                                lk_we = 1'b1;
                                lk_wa = r_tail;
                                lk_wd = r_slot;
                            end else begin
                                n_head     = r_slot;
                                n_nonempty = 1'b1;
                            end
                            n_tail = r_slot;
                            n_inq  = 1'b1;
                        end
                    end
                    FN_POP: begin
                        n_inq = member;
                        if (r_nonempty) begin
                            n_got   = 1'b1;
                            n_oslot = 6'(r_head);
                            mk_we   = 1'b1;
                            mk_wa   = r_head;
                            if (r_head == r_tail) begin
                                n_nonempty = 1'b0;
                            end else begin
                                n_head = r_link_rd;
                            end
                            if (r_head == r_slot) begin
                                n_inq = 1'b0;
                            end
                        end
                    end
                    FN_REMOVE: begin
                        if (!member) begin
                            n_status = STAT_REM_MISS;
                        end else if (r_head == r_slot) begin
                            mk_we = 1'b1;
                            if (r_tail == r_slot) begin
                                n_nonempty = 1'b0;
                            end else begin
                                n_head = r_link_rd;
                            end
                        end else begin
                            n_cur   = r_head;
                            n_state = ST_WALK;
                        end
                    end
                    default: begin
                        n_inq = member;
                    end
                endcase
            end
            ST_WALK: begin
                if (r_cur == r_tail) begin
                    n_state = ST_FIN;
                end else if (r_link_rd == r_slot) begin
                    mk_we = 1'b1;
                    if (r_tail == r_slot) begin
                        n_tail  = r_cur;
                        n_state = ST_FIN;
                    end else begin
                        lk_ra   = r_slot;
                        n_state = ST_UNLINK;
                    end
                end else begin
                    n_cur = r_link_rd;
                    lk_ra = r_link_rd;
                end
            end
            ST_UNLINK: begin
                lk_we   = 1'b1;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = OUT_W'({r_status, !r_nonempty, r_inq, r_got, r_oslot});
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_nonempty  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_nonempty  <= n_nonempty;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_slot     <= n_slot;
        r_inr      <= n_inr;
        r_cur      <= n_cur;
        r_got      <= n_got;
        r_oslot    <= n_oslot;
        r_inq      <= n_inq;
        r_status   <= n_status;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (mk_we) begin
            r_mark_mem[mk_wa] <= mk_wd;
        end
        r_mark_rd <= r_mark_mem[mk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (lk_we) begin
            r_link_mem[lk_wa] <= lk_wd;
        end
        r_link_rd <= r_link_mem[lk_ra];
    end

endmodule

`default_nettype wire

@@ design/llqm_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module llqm_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_s_axis_tvalid,
    input wire logic                        o_s_axis_tready,
    input wire logic [llqm_pkg::IN_W-1:0]   i_s_axis_tdata,   // func, item_slot
    input wire logic                        o_m_axis_tvalid,
    input wire logic                        i_m_axis_tready,
    input wire logic [llqm_pkg::OUT_W-1:0]  o_m_axis_tdata    // out_slot, got_item,
                                                             // in_queue, queue_empty, status
);
    import llqm_pkg::*;

    logic       in_acc;
    logic       got;
    logic       inq;
    logic [1:0] status;

    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign got    = o_m_axis_tdata[6];
    assign inq    = o_m_axis_tdata[7];
    assign status = o_m_axis_tdata[10:9];

    `LLQM_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
    `LLQM_ASSERT_NR(a_clear_after_reset, i_clk, !i_rst_n |=> !o_s_axis_tready)
    `LLQM_ASSERT(a_busy_after_accept, i_clk, i_rst_n, in_acc |=> !o_s_axis_tready)
    `LLQM_ASSERT(a_pop_status, i_clk, i_rst_n, o_m_axis_tvalid && got |-> status == STAT_OK)
    `LLQM_ASSERT(a_miss_result, i_clk, i_rst_n, o_m_axis_tvalid && status == STAT_REM_MISS |-> !inq && !got)

endmodule

bind linked_list_queue_manager llqm_checker u_llqm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
